[rtl/s2rd_pkg.sv]
// ----------------------------------------------------------------------------
// s2rd_pkg
// Types, constants and the alphabet lookup shared by the radix text converter.
// ----------------------------------------------------------------------------
package s2rd_pkg;

    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 5;
    localparam int ALPHA_W     = 64;
    localparam int ALPHA_CHARS = 16;
    localparam int CHAR_IDX_W  = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_HIGH   = 2'd2;

    localparam logic [LEN_W-1:0]   RST_ALPHABET_LENGTH = 5'd10;
    localparam logic [ALPHA_W-1:0] RST_ALPHABET_LOW    = 64'h3736353433323130;
    localparam logic [ALPHA_W-1:0] RST_ALPHABET_HIGH   = 64'h4645444342413938;

    typedef struct packed {
        logic done;
        logic ok;
    } chk_status_t;

    function automatic logic [CHAR_W-1:0] digit_char(
        input logic [ALPHA_W-1:0]    alpha_low,
        input logic [ALPHA_W-1:0]    alpha_high,
        input logic [CHAR_IDX_W-1:0] idx
    );
        logic [ALPHA_W-1:0] word;
        word = idx[CHAR_IDX_W-1] ? alpha_high : alpha_low;
        return word[idx[CHAR_IDX_W-2:0]*CHAR_W +: CHAR_W];
    endfunction

endpackage

[rtl/s2rd_if.sv]
// ----------------------------------------------------------------------------
// s2rd channel interfaces
// Valid/ready channels for the number input and the character output.
// ----------------------------------------------------------------------------
interface s2rd_num_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface s2rd_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       end_of_text;
    logic       bad_alphabet;

    modport source (output valid, output text_char, output end_of_text,
                    output bad_alphabet, input ready);
    modport sink   (input valid, input text_char, input end_of_text,
                    input bad_alphabet, output ready);
endinterface

[rtl/s2rd_alpha_check.sv]
// ----------------------------------------------------------------------------
// s2rd_alpha_check
// Walks the digit alphabet one character per cycle and flags a bad length,
// a sign character or a repeated character.
// ----------------------------------------------------------------------------
module s2rd_alpha_check
    import s2rd_pkg::*;
#(
    parameter int MAX_RADIX = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [LEN_W-1:0]   alpha_len,
    input  logic [ALPHA_W-1:0] alpha_low,
    input  logic [ALPHA_W-1:0] alpha_high,
    output chk_status_t        status
);

    logic                  running_reg;
    logic [CHAR_IDX_W-1:0] idx_reg;
    logic                  bad_reg;
    logic                  done_reg;
    logic                  ok_reg;

    logic                  len_bad;
    logic [CHAR_W-1:0]     cur_char;
    logic [ALPHA_CHARS-1:0] dup;
    logic                  bad_now;

    assign len_bad  = (alpha_len < 5'd2) || (alpha_len > LEN_W'(MAX_RADIX));
    assign cur_char = digit_char(alpha_low, alpha_high, idx_reg);

    always_comb
    begin
        for (int j = 0; j < ALPHA_CHARS; j++)
        begin
            dup[j] = (CHAR_IDX_W'(j) > idx_reg) && (LEN_W'(j) < alpha_len)
                     && (digit_char(alpha_low, alpha_high, CHAR_IDX_W'(j)) == cur_char);
        end
    end

    assign bad_now = ({1'b0, idx_reg} < alpha_len)
                     && ((cur_char == CH_MINUS) || (cur_char == CH_PLUS) || (|dup));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            idx_reg     <= '0;
            bad_reg     <= 1'b0;
            done_reg    <= 1'b0;
            ok_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                running_reg <= 1'b1;
                idx_reg     <= '0;
                bad_reg     <= len_bad;
            end
            else if (running_reg)
            begin
                bad_reg <= bad_reg | bad_now;
                if (idx_reg == CHAR_IDX_W'(ALPHA_CHARS - 1))
                begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                    ok_reg      <= !(bad_reg | bad_now);
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    assign status.done = done_reg;
    assign status.ok   = ok_reg;

endmodule

[rtl/s2rd_divider.sv]
// ----------------------------------------------------------------------------
// s2rd_divider
// Restoring serial divider: one quotient bit per cycle by a narrow radix.
// ----------------------------------------------------------------------------
module s2rd_divider #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_RADIX  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [VALUE_BITS-1:0]                 dividend,
    input  logic [$clog2(MAX_RADIX+1)-1:0]        radix,
    output logic                                  done,
    output logic [VALUE_BITS-1:0]                 quotient,
    output logic [$clog2(MAX_RADIX)-1:0]          remainder
);

    localparam int RADW = $clog2(MAX_RADIX + 1);
    localparam int DW   = $clog2(MAX_RADIX);
    localparam int CW   = $clog2(VALUE_BITS);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CW-1:0]         cnt_reg;
    logic [RADW-1:0]       rem_reg;
    logic [VALUE_BITS-1:0] quot_reg;

    logic [RADW:0]         trial;
    logic [RADW:0]         diff;
    logic                  qbit;
    logic [RADW-1:0]       rem_next;

    assign trial    = {rem_reg, quot_reg[VALUE_BITS-1]};
    assign diff     = trial - {1'b0, radix};
    assign qbit     = (trial >= {1'b0, radix});
    assign rem_next = qbit ? diff[RADW-1:0] : trial[RADW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(VALUE_BITS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quot_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[VALUE_BITS-2:0], qbit};
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg[DW-1:0];

endmodule

[rtl/signed_integer_to_radix_digits.sv]
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits
// Converts a signed number to text in a configurable radix, one character
// per output beat.
// ----------------------------------------------------------------------------
// Usage:
//   numbers : one signed VALUE_BITS-bit value per beat; ready only while idle.
//   chars   : one character per beat, most significant digit first, a leading
//             '-' for negative values, end_of_text on the last beat. A bad
//             alphabet gives a single beat with bad_alphabet and end_of_text.
//   cfg     : write alphabet_length (0), alphabet_low (1), alphabet_high (2)
//             only while idle; other indexes are dropped.
// Flow: the alphabet check runs first, then each digit takes one pass through
//   the shared serial divider, and the digits are then read back out of the
//   digit buffer one character per output beat. A new number is taken only
//   once the block is back in idle.
// Reset: the alphabet returns to "0123456789" and the block goes idle.
// A stalled receiver holds the output register; the sequencer waits on it
// and the next number may be taken while the last character is pending.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_digits
    import s2rd_pkg::*;
#(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    s2rd_num_if.sink              numbers,
    s2rd_char_if.source           chars
);

    localparam int RADW = $clog2(MAX_RADIX + 1);
    localparam int DW   = $clog2(MAX_RADIX);
    localparam int IW   = $clog2(VALUE_BITS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_LEAD   = 3'd2;
    localparam logic [2:0] ST_START  = 3'd3;
    localparam logic [2:0] ST_DIVIDE = 3'd4;
    localparam logic [2:0] ST_FETCH  = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [LEN_W-1:0]      alpha_len_reg;
    logic [ALPHA_W-1:0]    alpha_low_reg;
    logic [ALPHA_W-1:0]    alpha_high_reg;

    logic [2:0]            state_reg, state_next;
    logic [VALUE_BITS-1:0] num_reg;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [CHAR_W-1:0]     lead_char_reg, lead_char_next;
    logic                  lead_end_reg, lead_end_next;
    logic                  lead_bad_reg, lead_bad_next;
    logic [IW-1:0]         wr_idx_reg, wr_idx_next;
    logic [IW-1:0]         rd_idx_reg, rd_idx_next;
    logic [DW-1:0]         rd_data_reg;
    logic [DW-1:0]         digit_mem [VALUE_BITS];

    logic                  out_valid_reg;
    logic [CHAR_W-1:0]     out_char_reg;
    logic                  out_end_reg;
    logic                  out_bad_reg;
    logic                  out_free;
    logic                  out_load;
    logic [CHAR_W-1:0]     load_char;
    logic                  load_end;
    logic                  load_bad;

    logic                  in_accept;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quot;
    logic [DW-1:0]         div_rem;
    logic                  digit_wr;
    chk_status_t           chk_status;

    assign in_accept     = numbers.valid && numbers.ready;
    assign numbers.ready = (state_reg == ST_IDLE);
    assign out_free      = !out_valid_reg || chars.ready;
    assign digit_wr      = (state_reg == ST_DIVIDE) && div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_len_reg  <= RST_ALPHABET_LENGTH;
            alpha_low_reg  <= RST_ALPHABET_LOW;
            alpha_high_reg <= RST_ALPHABET_HIGH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ALPHABET_LENGTH: alpha_len_reg  <= cfg_data[LEN_W-1:0];
                CFG_ALPHABET_LOW:    alpha_low_reg  <= cfg_data;
                CFG_ALPHABET_HIGH:   alpha_high_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    s2rd_alpha_check #(
        .MAX_RADIX (MAX_RADIX)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_accept),
        .alpha_len  (alpha_len_reg),
        .alpha_low  (alpha_low_reg),
        .alpha_high (alpha_high_reg),
        .status     (chk_status)
    );

    s2rd_divider #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_RADIX  (MAX_RADIX)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == ST_START),
        .dividend  (mag_reg),
        .radix     (alpha_len_reg[RADW-1:0]),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        lead_char_next = lead_char_reg;
        lead_end_next  = lead_end_reg;
        lead_bad_next  = lead_bad_reg;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        out_load       = 1'b0;
        load_char      = lead_char_reg;
        load_end       = lead_end_reg;
        load_bad       = lead_bad_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (chk_status.done)
                begin
                    wr_idx_next   = '0;
                    mag_next      = num_reg[VALUE_BITS-1] ? (~num_reg + 1'b1) : num_reg;
                    lead_end_next = 1'b1;
                    lead_bad_next = 1'b0;
                    priority if (!chk_status.ok)
                    begin
                        lead_char_next = '0;
                        lead_bad_next  = 1'b1;
                        state_next     = ST_LEAD;
                    end
                    else if (num_reg == '0)
                    begin
                        lead_char_next = digit_char(alpha_low_reg, alpha_high_reg, '0);
                        state_next     = ST_LEAD;
                    end
                    else if (num_reg[VALUE_BITS-1])
                    begin
                        lead_char_next = CH_MINUS;
                        lead_end_next  = 1'b0;
                        state_next     = ST_LEAD;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_LEAD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = lead_end_reg ? ST_IDLE : ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    mag_next = div_quot;
                    if (div_quot == '0)
                    begin
                        rd_idx_next = wr_idx_reg;
                        state_next  = ST_FETCH;
                    end
                    else
                    begin
                        wr_idx_next = wr_idx_reg + 1'b1;
                        state_next  = ST_START;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                load_char = digit_char(alpha_low_reg, alpha_high_reg,
                                       CHAR_IDX_W'(rd_data_reg));
                load_end  = (rd_idx_reg == '0);
                load_bad  = 1'b0;
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (rd_idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg - 1'b1;
                        state_next  = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (chars.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            num_reg <= numbers.number;
        end
        mag_reg       <= mag_next;
        lead_char_reg <= lead_char_next;
        lead_end_reg  <= lead_end_next;
        lead_bad_reg  <= lead_bad_next;
        wr_idx_reg    <= wr_idx_next;
        rd_idx_reg    <= rd_idx_next;
        if (out_load)
        begin
            out_char_reg <= load_char;
            out_end_reg  <= load_end;
            out_bad_reg  <= load_bad;
        end
    end

    always_ff @(posedge clk)
    begin
        if (digit_wr)
        begin
            digit_mem[wr_idx_reg] <= div_rem;
        end
        if (state_reg == ST_FETCH)
        begin
            rd_data_reg <= digit_mem[rd_idx_reg];
        end
    end

    assign chars.valid        = out_valid_reg;
    assign chars.text_char    = out_char_reg;
    assign chars.end_of_text  = out_end_reg;
    assign chars.bad_alphabet = out_bad_reg;

`ifndef SYNTHESIS
    a_chk_done_in_check: assert property (@(posedge clk) disable iff (!rst_n)
        chk_status.done |-> state_reg == ST_CHECK)
        else $error("alphabet check finished outside the check state");

    a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIVIDE)
        else $error("divider finished outside the divide state");

    a_digit_buf_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (digit_wr && div_quot != '0) |-> wr_idx_reg != IW'(VALUE_BITS - 1))
        else $error("digit buffer overflow");

    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_bad_reg) |-> out_end_reg)
        else $error("bad alphabet beat without end of text");
`endif

endmodule
